// ===== rtl/ctsc_pkg.sv =====
`timescale 1ns / 1ps

package ctsc_pkg;

    // event codes, the fourth code is unused and changes nothing
    localparam logic [1:0] MODE_FWD   = 2'd0;
    localparam logic [1:0] MODE_BWD   = 2'd1;
    localparam logic [1:0] MODE_PRESS = 2'd2;

    // field select codes
    localparam logic [2:0] FIELD_YEAR   = 3'd0;
    localparam logic [2:0] FIELD_MONTH  = 3'd1;
    localparam logic [2:0] FIELD_DAY    = 3'd2;
    localparam logic [2:0] FIELD_HOUR   = 3'd3;
    localparam logic [2:0] FIELD_MINUTE = 3'd4;
    localparam logic [2:0] FIELD_SECOND = 3'd5;

    localparam logic [7:0] YEAR_MIN   = 8'd70;
    localparam logic [7:0] YEAR_MAX   = 8'd255;
    localparam logic [5:0] LOW_ZERO   = 6'd0;
    localparam logic [5:0] LOW_DAY    = 6'd1;
    localparam logic [5:0] MONTH_TOP  = 6'd11;
    localparam logic [5:0] DAY_TOP    = 6'd31;
    localparam logic [5:0] HOUR_TOP   = 6'd23;
    localparam logic [5:0] MINSEC_TOP = 6'd59;

    typedef struct packed {
        logic [7:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_time;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] now_year;
        logic [3:0] now_month;
        logic [4:0] now_day;
        logic [4:0] now_hour;
        logic [5:0] now_minute;
        logic [5:0] now_second;
    } t_event;

    typedef struct packed {
        logic       in_setting;
        logic [2:0] field_sel;
        logic [7:0] set_year;
        logic [3:0] set_month;
        logic [4:0] set_day;
        logic [4:0] set_hour;
        logic [5:0] set_minute;
        logic [5:0] set_second;
        logic       commit;
    } t_result;

    // step up, anything past top goes back to low
    function automatic logic [5:0] wrap_up(input logic [5:0] v, input logic [5:0] low,
                                           input logic [5:0] top);
        logic [6:0] n;
        n = {1'b0, v} + 7'd1;
        return (n > {1'b0, top}) ? low : n[5:0];
    endfunction

    // step down, at or below low goes to top
    function automatic logic [5:0] wrap_down(input logic [5:0] v, input logic [5:0] low,
                                             input logic [5:0] top);
        return (v <= low) ? top : (v - 6'd1);
    endfunction

endpackage

// ===== rtl/ctsc_if.sv =====
`timescale 1ns / 1ps

interface ctsc_evt_if;
    logic               valid;
    logic               ready;
    ctsc_pkg::t_event   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ctsc_res_if;
    logic               valid;
    logic               ready;
    ctsc_pkg::t_result  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/ctsc_step.sv =====
`timescale 1ns / 1ps

module ctsc_step (
    input  logic [2:0]      i_field,
    input  logic            i_forward,
    input  ctsc_pkg::t_time i_edit,
    output ctsc_pkg::t_time o_edit
);
    import ctsc_pkg::*;

    logic [5:0] w_month;
    logic [5:0] w_day;
    logic [5:0] w_hour;

    always_comb begin
        o_edit  = i_edit;
        w_month = 6'd0;
        w_day   = 6'd0;
        w_hour  = 6'd0;
        unique case (i_field)
            FIELD_YEAR: begin
                if (i_forward) begin
                    // saturates at the top
                    if (i_edit.year < YEAR_MAX) begin
                        o_edit.year = i_edit.year + 8'd1;
                    end
                end else begin
                    o_edit.year = (i_edit.year <= YEAR_MIN) ? YEAR_MIN : (i_edit.year - 8'd1);
                end
            end
            FIELD_MONTH: begin
                w_month = i_forward ? wrap_up({2'b00, i_edit.month}, LOW_ZERO, MONTH_TOP)
                                    : wrap_down({2'b00, i_edit.month}, LOW_ZERO, MONTH_TOP);
                o_edit.month = w_month[3:0];
            end
            FIELD_DAY: begin
                w_day = i_forward ? wrap_up({1'b0, i_edit.day}, LOW_DAY, DAY_TOP)
                                  : wrap_down({1'b0, i_edit.day}, LOW_DAY, DAY_TOP);
                o_edit.day = w_day[4:0];
            end
            FIELD_HOUR: begin
                w_hour = i_forward ? wrap_up({1'b0, i_edit.hour}, LOW_ZERO, HOUR_TOP)
                                   : wrap_down({1'b0, i_edit.hour}, LOW_ZERO, HOUR_TOP);
                o_edit.hour = w_hour[4:0];
            end
            FIELD_MINUTE: begin
                o_edit.minute = i_forward ? wrap_up(i_edit.minute, LOW_ZERO, MINSEC_TOP)
                                          : wrap_down(i_edit.minute, LOW_ZERO, MINSEC_TOP);
            end
            FIELD_SECOND: begin
                o_edit.second = i_forward ? wrap_up(i_edit.second, LOW_ZERO, MINSEC_TOP)
                                          : wrap_down(i_edit.second, LOW_ZERO, MINSEC_TOP);
            end
            default: begin
                o_edit = i_edit;
            end
        endcase
    end

endmodule

// ===== rtl/clock_time_setting_controller.sv =====
`timescale 1ns / 1ps

// Time-setting controller for a knob-driven clock. Each request carries a knob
// event (forward, backward, press) and the running clock time; each produces
// exactly one result carrying the mode, selected field, edited time and a
// commit strobe. A request can be accepted every cycle, and its result is in the
// output register in the cycle after it is taken. The only thing that holds off
// a new request is a result still sitting in that output register while the
// sink stalls; the edit state is updated in the same cycle the request is taken.

module clock_time_setting_controller (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ctsc_evt_if.sink         i_evt,
    ctsc_res_if.source       o_res
);
    import ctsc_pkg::*;

    logic       r_setting;
    logic [2:0] r_field;
    t_time      r_edit;
    logic       r_out_valid;
    t_result    r_out;

    logic       n_setting;
    logic [2:0] n_field;
    t_time      n_edit;
    logic       n_commit;

    logic       w_in_ready;
    logic       w_accept;
    t_time      w_stepped;
    t_time      w_captured;

    assign w_in_ready  = !r_out_valid || o_res.ready;
    assign w_accept    = i_evt.valid && w_in_ready;
    assign i_evt.ready = w_in_ready;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    assign w_captured.year   = i_evt.data.now_year;
    assign w_captured.month  = i_evt.data.now_month;
    assign w_captured.day    = i_evt.data.now_day;
    assign w_captured.hour   = i_evt.data.now_hour;
    assign w_captured.minute = i_evt.data.now_minute;
    assign w_captured.second = i_evt.data.now_second;

    ctsc_step u_step (
        .i_field   (r_field),
        .i_forward (i_evt.data.mode == MODE_FWD),
        .i_edit    (r_edit),
        .o_edit    (w_stepped)
    );

    always_comb begin
        n_setting = r_setting;
        n_field   = r_field;
        n_edit    = r_edit;
        n_commit  = 1'b0;
        if (w_accept) begin
            priority if (i_evt.data.mode == MODE_PRESS) begin
                priority if (!r_setting) begin
                    n_setting = 1'b1;
                    n_field   = FIELD_YEAR;
                    n_edit    = w_captured;
                end else if (r_field >= FIELD_SECOND) begin
                    n_setting = 1'b0;
                    n_commit  = 1'b1;
                end else begin
                    n_field = r_field + 3'd1;
                end
            end else if ((i_evt.data.mode == MODE_FWD || i_evt.data.mode == MODE_BWD)
                         && r_setting) begin
                n_edit = w_stepped;
            end else begin
                n_edit = r_edit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setting    <= 1'b0;
            r_field      <= FIELD_YEAR;
            r_edit.year  <= YEAR_MIN;
            r_edit.month <= 4'd0;
            r_edit.day   <= 5'd1;
            r_edit.hour  <= 5'd0;
            r_edit.minute <= 6'd0;
            r_edit.second <= 6'd0;
            r_out_valid  <= 1'b0;
        end else begin
            r_setting <= n_setting;
            r_field   <= n_field;
            r_edit    <= n_edit;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out.in_setting <= n_setting;
            r_out.field_sel  <= n_field;
            r_out.set_year   <= n_edit.year;
            r_out.set_month  <= n_edit.month;
            r_out.set_day    <= n_edit.day;
            r_out.set_hour   <= n_edit.hour;
            r_out.set_minute <= n_edit.minute;
            r_out.set_second <= n_edit.second;
            r_out.commit     <= n_commit;
        end
    end

endmodule

// ===== rtl/ctsc_checker.sv =====
`timescale 1ns / 1ps

module ctsc_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  ctsc_pkg::t_result i_out_data
);
    import ctsc_pkg::*;

    // nothing left in the output register coming out of reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // a request is never taken while a stalled result would be overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |-> (!i_out_valid || i_out_ready))
        else $error("request taken over a stalled result");

    // commit only leaving the seconds field back to normal mode
    a_commit_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_data.commit) |->
            (!i_out_data.in_setting && i_out_data.field_sel == FIELD_SECOND))
        else $error("commit without leaving seconds field");

    a_field_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_data.field_sel <= FIELD_SECOND))
        else $error("field select out of range");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled result changed");

endmodule

bind clock_time_setting_controller ctsc_checker u_ctsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_evt.valid),
    .i_in_ready  (i_evt.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.data)
);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import ctsc_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int RANDOM_EVENTS = 1000;
    localparam int DRAIN_EVERY = 200;
    localparam int SHOWN_MISMATCHES = 10;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ctsc_evt_if evt_if ();
    ctsc_res_if res_if ();

    clock_time_setting_controller dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt_if),
        .o_res   (res_if)
    );

    t_event  knob_events[$];
    t_result awaited_views[$];

    // shadow of the setting state
    logic       editing;
    logic [2:0] cur_field;
    t_time      edit;

    int total_events = 0;
    int events_sent = 0;
    int views_seen = 0;
    int commits_seen = 0;
    int captures = 0;
    int wild_captures = 0;
    int errors = 0;
    int mismatches = 0;
    logic request_taken;

    int sender_idle[3] = '{9, 53, 0};
    int receiver_stall[3] = '{53, 9, 0};

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int run_phase();
        int p;
        p = (total_events == 0) ? 0 : events_sent * 3 / total_events;
        return (p > 2) ? 2 : p;
    endfunction

    function automatic int step_wrap(int v, int lo, int top, bit fwd);
        if (fwd)
            return (v + 1 > top) ? lo : v + 1;
        return (v <= lo) ? top : v - 1;
    endfunction

    function automatic t_event random_knob_event(logic [1:0] mode);
        t_event ev;
        ev.mode = mode;
        if ($urandom_range(3) == 0) begin
            // raw bits, field ranges ignored
            ev.now_year   = 8'($urandom);
            ev.now_month  = 4'($urandom);
            ev.now_day    = ($urandom_range(3) == 0) ? 5'd0 : 5'($urandom);
            ev.now_hour   = 5'($urandom);
            ev.now_minute = 6'($urandom);
            ev.now_second = 6'($urandom);
        end else begin
            ev.now_year   = 8'($urandom_range(255));
            ev.now_month  = 4'($urandom_range(11));
            ev.now_day    = 5'($urandom_range(31, 1));
            ev.now_hour   = 5'($urandom_range(23));
            ev.now_minute = 6'($urandom_range(59));
            ev.now_second = 6'($urandom_range(59));
        end
        return ev;
    endfunction

    function automatic t_result apply_knob_event(t_event ev);
        t_result r;
        bit fwd;
        r.commit = 1'b0;
        fwd = (ev.mode == MODE_FWD);
        if (ev.mode == MODE_PRESS) begin
            if (!editing) begin
                editing = 1'b1;
                cur_field = FIELD_YEAR;
                edit = '{ev.now_year, ev.now_month, ev.now_day, ev.now_hour,
                         ev.now_minute, ev.now_second};
                captures++;
                if (ev.now_month > MONTH_TOP || ev.now_day < LOW_DAY
                        || ev.now_hour > HOUR_TOP || ev.now_minute > MINSEC_TOP
                        || ev.now_second > MINSEC_TOP)
                    wild_captures++;
            end else if (cur_field >= FIELD_SECOND) begin
                editing = 1'b0;
                r.commit = 1'b1;
            end else begin
                cur_field = cur_field + 3'd1;
            end
        end else if ((ev.mode == MODE_FWD || ev.mode == MODE_BWD) && editing) begin
            case (cur_field)
                FIELD_YEAR: begin
                    // clamps low, saturates high
                    if (fwd) begin
                        if (edit.year < YEAR_MAX)
                            edit.year = edit.year + 8'd1;
                    end else begin
                        edit.year = (edit.year <= YEAR_MIN) ? YEAR_MIN : edit.year - 8'd1;
                    end
                end
                FIELD_MONTH:  edit.month  = 4'(step_wrap(edit.month, LOW_ZERO, MONTH_TOP, fwd));
                FIELD_DAY:    edit.day    = 5'(step_wrap(edit.day, LOW_DAY, DAY_TOP, fwd));
                FIELD_HOUR:   edit.hour   = 5'(step_wrap(edit.hour, LOW_ZERO, HOUR_TOP, fwd));
                FIELD_MINUTE: edit.minute = 6'(step_wrap(edit.minute, LOW_ZERO, MINSEC_TOP, fwd));
                FIELD_SECOND: edit.second = 6'(step_wrap(edit.second, LOW_ZERO, MINSEC_TOP, fwd));
                default: ;
            endcase
        end
        r.in_setting = editing;
        r.field_sel  = cur_field;
        r.set_year   = edit.year;
        r.set_month  = edit.month;
        r.set_day    = edit.day;
        r.set_hour   = edit.hour;
        r.set_minute = edit.minute;
        r.set_second = edit.second;
        return r;
    endfunction

    // request side
    always @(negedge i_clk) begin : feed_requests
        bit draining;
        draining = events_sent != 0 && events_sent % DRAIN_EVERY == 0
                   && awaited_views.size() != 0;
        if (i_rst_n && (!evt_if.valid || request_taken)) begin
            if (knob_events.size() != 0 && !draining
                    && $urandom_range(99) >= sender_idle[run_phase()]) begin
                evt_if.valid <= 1'b1;
                evt_if.data  <= knob_events.pop_front();
            end else begin
                evt_if.valid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin : pull_results
        if (i_rst_n)
            res_if.ready <= ($urandom_range(99) >= receiver_stall[run_phase()]);
    end

    always @(posedge i_clk) begin : watch_results
        t_result want;
        t_result got;
        if (i_rst_n) begin
            // results first, a request taken on this edge cannot have answered yet
            if (res_if.valid && res_if.ready) begin
                got = res_if.data;
                views_seen++;
                if (got.commit)
                    commits_seen++;
                if (awaited_views.size() == 0) begin
                    errors++;
                    mismatches++;
                    if (mismatches <= SHOWN_MISMATCHES)
                        $display("%0t: result arrived with none outstanding", $time);
                end else begin
                    want = awaited_views.pop_front();
                    if (got.in_setting !== want.in_setting || got.field_sel !== want.field_sel
                            || got.set_year !== want.set_year
                            || got.set_month !== want.set_month
                            || got.set_day !== want.set_day
                            || got.set_hour !== want.set_hour
                            || got.set_minute !== want.set_minute
                            || got.set_second !== want.set_second
                            || got.commit !== want.commit) begin
                        errors++;
                        mismatches++;
                        if (mismatches <= SHOWN_MISMATCHES) begin
                            $display("%0t: mismatch on result %0d", $time, views_seen);
                            $display("  exp set=%0d fld=%0d %0d/%0d/%0d %0d:%0d:%0d commit=%0d",
                                     want.in_setting, want.field_sel, want.set_year,
                                     want.set_month, want.set_day, want.set_hour,
                                     want.set_minute, want.set_second, want.commit);
                            $display("  got set=%0d fld=%0d %0d/%0d/%0d %0d:%0d:%0d commit=%0d",
                                     got.in_setting, got.field_sel, got.set_year,
                                     got.set_month, got.set_day, got.set_hour,
                                     got.set_minute, got.set_second, got.commit);
                        end
                    end
                end
            end
            if (evt_if.valid && evt_if.ready) begin
                awaited_views.push_back(apply_knob_event(evt_if.data));
                events_sent++;
            end
            request_taken <= evt_if.valid && evt_if.ready;
        end
    end

    initial begin : run
        int f, n, r, directed;
        logic [1:0] odd_steps [6];
        logic [1:0] knob;
        odd_steps = '{MODE_BWD, MODE_FWD, MODE_BWD, MODE_FWD, MODE_BWD, MODE_FWD};

        evt_if.valid = 1'b0;
        evt_if.data = '0;
        res_if.ready = 1'b0;
        request_taken = 1'b0;
        editing = 1'b0;
        cur_field = FIELD_YEAR;
        edit = '{YEAR_MIN, 4'd0, 5'd1, 5'd0, 6'd0, 6'd0};

        // knob and unused code while not setting, then a pass at the top of every field
        knob_events.push_back(random_knob_event(MODE_FWD));
        knob_events.push_back(random_knob_event(MODE_UNUSED));
        knob_events.push_back(t_event'{MODE_PRESS, 8'd255, 4'd11, 5'd31, 5'd23, 6'd59, 6'd59});
        for (f = 0; f < 6; f++) begin
            knob_events.push_back(random_knob_event(MODE_FWD));
            knob_events.push_back(random_knob_event(MODE_PRESS));
        end
        // captured time beyond every range
        knob_events.push_back(t_event'{MODE_PRESS, 8'd0, 4'd15, 5'd0, 5'd31, 6'd63, 6'd63});
        for (f = 0; f < 6; f++) begin
            if (f != 4)
                knob_events.push_back(random_knob_event(odd_steps[f]));
            knob_events.push_back(random_knob_event(MODE_PRESS));
        end
        directed = knob_events.size();

        // mostly complete edit sessions, now and then stray events
        while (knob_events.size() < directed + RANDOM_EVENTS) begin
            if ($urandom_range(7) == 0)
                repeat ($urandom_range(4, 1))
                    knob_events.push_back(random_knob_event(2'($urandom_range(3))));
            knob_events.push_back(random_knob_event(MODE_PRESS));
            for (f = 0; f < 6; f++) begin
                n = ($urandom_range(7) == 0) ? $urandom_range(70) : $urandom_range(4);
                repeat (n) begin
                    r = $urandom_range(19);
                    knob = (r == 0) ? MODE_UNUSED : ((r % 2) ? MODE_BWD : MODE_FWD);
                    knob_events.push_back(random_knob_event(knob));
                end
                knob_events.push_back(random_knob_event(MODE_PRESS));
            end
        end
        total_events = knob_events.size();

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (events_sent < total_events) @(posedge i_clk);
        while (awaited_views.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("%0d knob requests (%0d directed), %0d results checked, %0d errors",
                 events_sent, directed, views_seen, errors);
        $display("%0d time captures (%0d outside field ranges), %0d commits",
                 captures, wild_captures, commits_seen);
        if (errors == 0)
            $display("PASS clock_time_setting_controller");
        else
            $display("FAIL clock_time_setting_controller");
        $finish;
    end

    initial begin : watchdog
        #4_000_000;
        $display("timeout with %0d of %0d requests taken", events_sent, total_events);
        $display("FAIL clock_time_setting_controller");
        $finish;
    end

endmodule
